@@ rtl/sdst_pkg.sv @@
package sdst_pkg;

    // Request operations
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Finishing status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CMD_REJ   = 3'd1;
    localparam logic [2:0] ST_INIT_TO   = 3'd2;
    localparam logic [2:0] ST_READ_TO   = 3'd3;
    localparam logic [2:0] ST_WR_PROT   = 3'd4;
    localparam logic [2:0] ST_DATA_REJ  = 3'd5;
    localparam logic [2:0] ST_WRITE_TO  = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_INIT_RETRY = 2'd0;
    localparam logic [1:0] CFG_READ_WAIT  = 2'd1;
    localparam logic [1:0] CFG_WRITE_WAIT = 2'd2;

    // Card command codes
    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_SEND_OP  = 6'd1;
    localparam logic [5:0] CMD_RD_BLOCK = 6'd17;
    localparam logic [5:0] CMD_WR_BLOCK = 6'd24;

    localparam logic [15:0] INIT_RETRY_RST = 16'd10000;
    localparam logic [15:0] READ_WAIT_RST  = 16'd25000;
    localparam logic [19:0] WRITE_WAIT_RST = 20'd250000;

    // Sequencing counts, all compared against the 10-bit byte counter
    localparam logic [9:0] SECTOR_BYTES   = 10'd512;
    localparam logic [9:0] RESPONSE_POLLS = 10'd8;
    localparam logic [9:0] WARMUP_BYTES   = 10'd10;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_DATA_W = 20;

    typedef struct packed {
        logic        kind;
        logic [1:0]  operation;
        logic [22:0] sector_number;
        logic        write_protect;
        logic [7:0]  received_byte;
        logic [7:0]  write_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] send_byte;
        logic       select_n;
        logic       exchange_needed;
        logic       need_write_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [2:0] status;
    } t_result;

    typedef struct packed {
        logic [15:0] init_retry_limit;
        logic [15:0] read_wait_limit;
        logic [19:0] write_wait_limit;
    } t_limits;

endpackage

@@ rtl/sd_spi_sector_transfer_engine.sv @@
// Channel   Dir  Handshake                      Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata[47:0], tuser = kind
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata[23:0]
// cfg       in   i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// One item per clock sustained while results are taken. An item is registered on
// entry; when the output register is free, the sequencer updates its state and
// loads the result register, which drives m_axis.
// Reset is synchronous: sequencer idle, limits back to defaults.
// A stalled result holds in the output register; the input register takes one
// more item, then o_s_axis_tready drops until the result is taken.
module sd_spi_sector_transfer_engine
    import sdst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [1:0] operation, [24:2] sector_number, [25] write_protect,
    // [33:26] received_byte, [41:34] write_byte, [47:42] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] kind
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] send_byte, [8] select_n, [9] exchange_needed, [10] need_write_byte,
    // [11] read_valid, [19:12] read_byte, [20] done_res, [23:21] status
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    w_out_free;
    logic    w_adv;
    logic    w_has;
    t_result w_res;
    t_limits w_limits;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.kind          <= i_s_axis_tuser;
            r_in.operation     <= i_s_axis_tdata[1:0];
            r_in.sector_number <= i_s_axis_tdata[24:2];
            r_in.write_protect <= i_s_axis_tdata[25];
            r_in.received_byte <= i_s_axis_tdata[33:26];
            r_in.write_byte    <= i_s_axis_tdata[41:34];
        end
    end

    sdst_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cfg_valid && o_cfg_ready),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_limits (w_limits)
    );

    sdst_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_item       (r_in),
        .i_limits     (w_limits),
        .o_has_result (w_has),
        .o_result     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid && w_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_has) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.status, r_out.done_res, r_out.read_byte,
                              r_out.read_valid, r_out.need_write_byte,
                              r_out.exchange_needed, r_out.select_n, r_out.send_byte};

endmodule

@@ rtl/sdst_cfg.sv @@
module sdst_cfg
    import sdst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [1:0]            i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_limits               o_limits
);

    t_limits r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.init_retry_limit <= INIT_RETRY_RST;
            r_limits.read_wait_limit  <= READ_WAIT_RST;
            r_limits.write_wait_limit <= WRITE_WAIT_RST;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_INIT_RETRY: r_limits.init_retry_limit <= i_data[15:0];
                CFG_READ_WAIT:  r_limits.read_wait_limit  <= i_data[15:0];
                CFG_WRITE_WAIT: r_limits.write_wait_limit <= i_data[19:0];
                default: ;
            endcase
        end
    end

    assign o_limits = r_limits;

endmodule

@@ rtl/sdst_seq.sv @@
module sdst_seq
    import sdst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_limits i_limits,
    output logic    o_has_result,
    output t_result o_result
);

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_WARMUP  = 5'd1;
    localparam logic [4:0] PH_CMD     = 5'd2;
    localparam logic [4:0] PH_RESP    = 5'd3;
    localparam logic [4:0] PH_DESEL   = 5'd4;
    localparam logic [4:0] PH_RD_WAIT = 5'd5;
    localparam logic [4:0] PH_RD_DATA = 5'd6;
    localparam logic [4:0] PH_RD_CRC  = 5'd7;
    localparam logic [4:0] PH_WR_DATA = 5'd8;
    localparam logic [4:0] PH_WR_CRC  = 5'd9;
    localparam logic [4:0] PH_WR_ACK  = 5'd10;
    localparam logic [4:0] PH_WR_BUSY = 5'd11;
    localparam logic [4:0] PH_FIN     = 5'd16;

    localparam logic [7:0] TOK_IDLE   = 8'hFF;
    localparam logic [7:0] TOK_START  = 8'hFE;
    localparam logic [7:0] CMD_CRC    = 8'h95;
    localparam logic [3:0] TOK_DATA_OK = 4'h5;
    localparam logic [9:0] FRAME_BYTES = 10'd6;
    localparam logic [9:0] CRC_BYTES   = 10'd2;

    logic [4:0]  r_phase, n_phase;
    logic [1:0]  r_op, n_op;
    logic [9:0]  r_bc, n_bc;
    logic [19:0] r_wait, n_wait;
    logic [22:0] r_sector, n_sector;
    logic [5:0]  r_code, n_code;

    logic [19:0] w_wait_inc;
    logic [9:0]  w_bc_inc;
    logic        w_start;
    logic [5:0]  w_start_code;
    logic        w_fin;
    logic [2:0]  w_fin_st;
    t_result     w_res;
    logic        w_has;

    // Command frame: command byte, byte address MSB first (sector * 512), CRC
    function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [5:0] code,
                                              input logic [22:0] sec);
        logic [7:0] b;
        case (idx)
            3'd0:    b = {2'b01, code};
            3'd1:    b = sec[22:15];
            3'd2:    b = sec[14:7];
            3'd3:    b = {sec[6:0], 1'b0};
            3'd4:    b = 8'h00;
            default: b = CMD_CRC;
        endcase
        return b;
    endfunction

    assign w_wait_inc = r_wait + 20'd1;
    assign w_bc_inc   = r_bc + 10'd1;

    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_bc     = r_bc;
        n_wait   = r_wait;
        n_sector = r_sector;
        n_code   = r_code;
        w_has    = 1'b0;
        w_start  = 1'b0;
        w_start_code = CMD_GO_IDLE;
        w_fin    = 1'b0;
        w_fin_st = ST_OK;
        w_res    = '{send_byte: TOK_IDLE, select_n: 1'b1, exchange_needed: 1'b0,
                     need_write_byte: 1'b0, read_valid: 1'b0, read_byte: 8'h00,
                     done_res: 1'b0, status: ST_OK};

        if (!i_item.kind) begin
            if (r_phase == PH_IDLE) begin
                w_has = 1'b1;
                if (i_item.operation != OP_INIT && i_item.operation != OP_READ &&
                    i_item.operation != OP_WRITE) begin
                    w_res.done_res = 1'b1;
                    w_res.status   = ST_CMD_REJ;
                end else if (i_item.operation == OP_WRITE && i_item.write_protect) begin
                    w_res.done_res = 1'b1;
                    w_res.status   = ST_WR_PROT;
                end else begin
                    n_op   = i_item.operation;
                    n_wait = '0;
                    if (i_item.operation == OP_INIT) begin
                        n_sector = '0;
                        n_bc     = 10'd1;
                        n_phase  = PH_WARMUP;
                        w_res.exchange_needed = 1'b1;
                    end else begin
                        n_sector     = i_item.sector_number;
                        w_start      = 1'b1;
                        w_start_code = (i_item.operation == OP_READ) ? CMD_RD_BLOCK
                                                                     : CMD_WR_BLOCK;
                    end
                end
            end
        end else if (r_phase >= PH_FIN) begin
            w_has          = 1'b1;
            n_phase        = PH_IDLE;
            w_res.done_res = 1'b1;
            w_res.status   = r_phase[2:0];
        end else begin
            w_has = 1'b1;
            w_res.select_n        = 1'b0;
            w_res.exchange_needed = 1'b1;
            unique case (r_phase)
                PH_WARMUP: begin
                    if (r_bc < WARMUP_BYTES) begin
                        n_bc = w_bc_inc;
                        w_res.select_n = 1'b1;
                    end else begin
                        w_start      = 1'b1;
                        w_start_code = CMD_GO_IDLE;
                    end
                end
                PH_CMD: begin
                    if (r_bc < FRAME_BYTES) begin
                        w_res.send_byte = frame_byte(r_bc[2:0], r_code, r_sector);
                        n_bc = w_bc_inc;
                    end else begin
                        n_bc    = 10'd1;
                        n_phase = PH_RESP;
                    end
                end
                PH_RESP: begin
                    if (i_item.received_byte != TOK_IDLE || r_bc >= RESPONSE_POLLS) begin
                        if (r_op == OP_INIT) begin
                            if (r_code == CMD_GO_IDLE) begin
                                if (i_item.received_byte != 8'd1) begin
                                    w_fin = 1'b1; w_fin_st = ST_CMD_REJ;
                                end else begin
                                    n_wait = '0;
                                    if (i_limits.init_retry_limit == '0) begin
                                        w_fin = 1'b1; w_fin_st = ST_INIT_TO;
                                    end else begin
                                        n_phase = PH_DESEL;
                                        w_res.select_n = 1'b1;
                                    end
                                end
                            end else if (i_item.received_byte == 8'd0) begin
                                w_fin = 1'b1; w_fin_st = ST_OK;
                            end else begin
                                n_wait = w_wait_inc;
                                if (w_wait_inc >= {4'd0, i_limits.init_retry_limit}) begin
                                    w_fin = 1'b1; w_fin_st = ST_INIT_TO;
                                end else begin
                                    n_phase = PH_DESEL;
                                    w_res.select_n = 1'b1;
                                end
                            end
                        end else if (i_item.received_byte != 8'd0) begin
                            // 0xFE here is a failed command, not a data token
                            w_fin = 1'b1; w_fin_st = ST_CMD_REJ;
                        end else if (r_op == OP_READ) begin
                            if (i_limits.read_wait_limit == '0) begin
                                w_fin = 1'b1; w_fin_st = ST_READ_TO;
                            end else begin
                                n_wait  = 20'd1;
                                n_phase = PH_RD_WAIT;
                            end
                        end else begin
                            n_bc    = '0;
                            n_phase = PH_WR_DATA;
                            w_res.send_byte       = TOK_START;
                            w_res.need_write_byte = 1'b1;
                        end
                    end else begin
                        n_bc = w_bc_inc;
                    end
                end
                PH_DESEL: begin
                    w_start      = 1'b1;
                    w_start_code = CMD_SEND_OP;
                end
                PH_RD_WAIT: begin
                    if (i_item.received_byte == TOK_START) begin
                        n_bc    = '0;
                        n_phase = PH_RD_DATA;
                    end else if (r_wait >= {4'd0, i_limits.read_wait_limit}) begin
                        w_fin = 1'b1; w_fin_st = ST_READ_TO;
                    end else begin
                        n_wait = w_wait_inc;
                    end
                end
                PH_RD_DATA: begin
                    n_bc = w_bc_inc;
                    if (w_bc_inc >= SECTOR_BYTES) begin
                        n_bc    = '0;
                        n_phase = PH_RD_CRC;
                    end
                    w_res.read_valid = 1'b1;
                    w_res.read_byte  = i_item.received_byte;
                end
                PH_RD_CRC: begin
                    if (r_bc == '0) begin
                        n_bc = 10'd1;
                    end else begin
                        w_fin = 1'b1; w_fin_st = ST_OK;
                    end
                end
                PH_WR_DATA: begin
                    n_bc = w_bc_inc;
                    w_res.send_byte = i_item.write_byte;
                    if (w_bc_inc >= SECTOR_BYTES) begin
                        n_bc    = '0;
                        n_phase = PH_WR_CRC;
                    end else begin
                        w_res.need_write_byte = 1'b1;
                    end
                end
                PH_WR_CRC: begin
                    if (r_bc < CRC_BYTES) begin
                        n_bc = w_bc_inc;
                    end else begin
                        n_phase = PH_WR_ACK;
                    end
                end
                PH_WR_ACK: begin
                    if (i_item.received_byte[3:0] != TOK_DATA_OK) begin
                        w_fin = 1'b1; w_fin_st = ST_DATA_REJ;
                    end else if (i_limits.write_wait_limit == '0) begin
                        w_fin = 1'b1; w_fin_st = ST_WRITE_TO;
                    end else begin
                        n_wait  = 20'd1;
                        n_phase = PH_WR_BUSY;
                    end
                end
                PH_WR_BUSY: begin
                    if (i_item.received_byte != 8'd0) begin
                        w_fin = 1'b1; w_fin_st = ST_OK;
                    end else if (r_wait >= i_limits.write_wait_limit) begin
                        w_fin = 1'b1; w_fin_st = ST_WRITE_TO;
                    end else begin
                        n_wait = w_wait_inc;
                    end
                end
                default: begin
                    // exchange while idle: dropped
                    w_has = 1'b0;
                    w_res.select_n        = 1'b1;
                    w_res.exchange_needed = 1'b0;
                end
            endcase
        end

        if (w_start) begin
            n_code  = w_start_code;
            n_bc    = 10'd1;
            n_phase = PH_CMD;
            w_res.send_byte       = {2'b01, w_start_code};
            w_res.select_n        = 1'b0;
            w_res.exchange_needed = 1'b1;
        end

        // last deselected byte; its reply yields the done result
        if (w_fin) begin
            n_phase = PH_FIN | {2'b00, w_fin_st};
            w_res.send_byte       = TOK_IDLE;
            w_res.select_n        = 1'b1;
            w_res.exchange_needed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_op     <= OP_INIT;
            r_bc     <= '0;
            r_wait   <= '0;
            r_sector <= '0;
            r_code   <= CMD_GO_IDLE;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_bc     <= n_bc;
            r_wait   <= n_wait;
            r_sector <= n_sector;
            r_code   <= n_code;
        end
    end

    assign o_has_result = w_has;
    assign o_result     = w_res;

endmodule

@@ rtl/sdst_checker.sv @@
module sdst_checker
    import sdst_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic                  i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [1:0]            i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // finishing result deselects and asks for no exchange
    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[20] |->
            o_m_axis_tdata[7:0] == 8'hFF && o_m_axis_tdata[8] && !o_m_axis_tdata[9])
        else $error("bad finishing result");

    // status only on a finishing result
    a_status_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[20] |-> o_m_axis_tdata[23:21] == ST_OK)
        else $error("status without done");

    // sector data only while selected and not writing
    a_read_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[11] |->
            !o_m_axis_tdata[8] && !o_m_axis_tdata[10] && o_m_axis_tdata[9])
        else $error("read byte outside a selected read");

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sd_spi_sector_transfer_engine sdst_checker u_sdst_checker (.*);
